### rtl/crtcr_pkg.sv
// Shared types and constants for the CRT character cell line renderer.
// No dependencies. Imported by every module of the block.
`timescale 1ns / 1ps

package crtcr_pkg;

    // stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    // field widths
    localparam int CODE_W    = 7;
    localparam int LINE_W    = 4;
    localparam int ATTR_W    = 4;
    localparam int FADDR_W   = 11;
    localparam int FDATA_W   = 8;
    localparam int GLINE_W   = 3;
    localparam int COLOR_W   = 3;
    localparam int PIX_COUNT = 6;
    localparam int PIX_W     = PIX_COUNT * COLOR_W;
    localparam int LINE_SPAN = 1 << LINE_W;
    localparam int FONT_LINES = 8;
    localparam int FONT_DEPTH = 1 << FADDR_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLOR_MODE   = 3'd0,
        CFG_FONT_SET     = 3'd1,
        CFG_LINES_PER_ROW = 3'd2,
        CFG_OFFSET_LINE  = 3'd3,
        CFG_DASHED_UL    = 3'd4,
        CFG_USE_REVERSE  = 3'd5
    } crtcr_cfg_idx_t;

    // color modes; the reserved code behaves as color
    localparam logic [1:0] COLOR_MONO  = 2'd0;
    localparam logic [1:0] COLOR_COLOR = 2'd1;
    localparam logic [1:0] COLOR_GRAY  = 2'd2;

    // command codes carried in tuser
    localparam logic CMD_RENDER  = 1'b0;
    localparam logic CMD_FONT_WR = 1'b1;

    // attribute bit positions
    localparam int ATTR_REV  = 0;
    localparam int ATTR_GPA0 = 1;
    localparam int ATTR_GPA1 = 2;
    localparam int ATTR_HGLT = 3;

    // mono foreground colors
    localparam logic [COLOR_W-1:0] FG_MONO_HI = 3'b011;
    localparam logic [COLOR_W-1:0] FG_MONO_LO = 3'b010;

    // glyph bit that, when clear on a non-blank line, sets a dashed underline flag
    localparam int UL_KEEP_BIT = 2;

    // reset values of the configuration registers
    localparam logic [1:0] RST_COLOR_MODE = COLOR_COLOR;
    localparam logic [4:0] RST_LINES_PER_ROW = 5'd10;

    // render beat carried from the font read to the pixel stage
    typedef struct packed {
        logic [COLOR_W-1:0] fg;
        logic               invert;
        logic               underline;
        logic               blank;
        logic [LINE_W-1:0]  line_index;
        logic               row_start;
    } crtcr_item_t;

endpackage

### rtl/crtcr_font_ram.sv
// Font store: 2048 x 8 single-port-write, registered-read memory.
// Depends on crtcr_pkg for widths.
`timescale 1ns / 1ps

module crtcr_font_ram (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [crtcr_pkg::FADDR_W-1:0] wr_addr,
    input  logic [crtcr_pkg::FDATA_W-1:0] wr_data,
    input  logic                          rd_en,
    input  logic [crtcr_pkg::FADDR_W-1:0] rd_addr,
    output logic [crtcr_pkg::FDATA_W-1:0] rd_data
);
    import crtcr_pkg::*;

    logic [FDATA_W-1:0] mem [FONT_DEPTH];
    logic [FDATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held while stalled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/crtcr_render.sv
// Pixel stage: underline line memory and pixel color composition.
// Depends on crtcr_pkg for the render item type and widths.
`timescale 1ns / 1ps

module crtcr_render #(
    parameter int CHAR_WIDTH = 6,
    parameter int MAX_LINES  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic                          dashed_underline,
    input  crtcr_pkg::crtcr_item_t        item,
    input  logic [crtcr_pkg::FDATA_W-1:0] glyph,
    output logic [crtcr_pkg::PIX_W-1:0]   pixel_colors
);
    import crtcr_pkg::*;

    localparam int UL_IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;

    logic [MAX_LINES-1:0] ul_mem_reg;
    logic [MAX_LINES-1:0] ul_mem_next;
    logic [UL_IW-1:0]     line_slot [LINE_SPAN];
    logic [UL_IW-1:0]     slot;
    logic                 old_flag;
    logic                 cur_ul;
    logic                 new_flag;

    // line index to memory slot, wraps at the memory depth
    for (genvar g = 0; g < LINE_SPAN; g++)
    begin : g_slot
        assign line_slot[g] = UL_IW'(g % MAX_LINES);
    end

    assign slot = line_slot[item.line_index];

    // underline flag for this line, cleared at row start
    always_comb
    begin
        old_flag = item.row_start ? 1'b0 : ul_mem_reg[slot];
        cur_ul   = dashed_underline ? (item.underline && !old_flag) : item.underline;
        new_flag = cur_ul;
        if (dashed_underline && !(item.blank || glyph[UL_KEEP_BIT]))
        begin
            new_flag = 1'b1;
        end
    end

    // memory update
    always_comb
    begin
        ul_mem_next = ul_mem_reg;
        if (update)
        begin
            if (item.row_start)
            begin
                ul_mem_next = '0;
            end
            ul_mem_next[slot] = new_flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ul_mem_reg <= '0;
        end
        else
        begin
            ul_mem_reg <= ul_mem_next;
        end
    end

    // pixel colors, leftmost pixel in the top bits
    for (genvar pt = 0; pt < PIX_COUNT; pt++)
    begin : g_pix
        if (pt < CHAR_WIDTH)
        begin : g_on
            logic lit;
            assign lit = (cur_ul || !(item.blank || glyph[CHAR_WIDTH-1-pt])) ^ item.invert;
            assign pixel_colors[PIX_W-1-COLOR_W*pt -: COLOR_W] =
                lit ? item.fg : '0;
        end
        else
        begin : g_off
            assign pixel_colors[PIX_W-1-COLOR_W*pt -: COLOR_W] = '0;
        end
    end

endmodule

### rtl/crt_char_cell_line_renderer.sv
// A render beat passes the font store read and stage registers, then the output register.
// Throughput: one beat per cycle; the input stalls only while the output register is full
// and m_tready is low. Font write beats give no output beat.
// The stages are the font store read port and the pixel stage behind it.
// Reset: pipeline and output empty, registers at defaults, underline lines cleared;
// the font store is not cleared and must be written before it is used.
`timescale 1ns / 1ps

module crt_char_cell_line_renderer #(
    parameter int CHAR_WIDTH = 6,
    parameter int MAX_LINES  = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [crtcr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [crtcr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // char_code, line_index, blank_line, underline, cell_attr, next_cell_attr,
    // row_start, font_addr, font_data, zero fill
    input  logic [crtcr_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,   // last_in_row
    input  logic                             s_tuser,   // cmd
    // output stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // pixel_colors, zero fill
    output logic [crtcr_pkg::M_TDATA_W-1:0]  m_tdata
);
    import crtcr_pkg::*;

    // configuration registers
    logic [1:0] color_mode_reg;
    logic       font_set_reg;
    logic [4:0] lines_per_row_reg;
    logic       offset_line_reg;
    logic       dashed_ul_reg;
    logic       use_reverse_reg;

    // input fields
    logic [CODE_W-1:0]  char_code;
    logic [LINE_W-1:0]  line_index;
    logic               blank_line;
    logic               underline;
    logic [ATTR_W-1:0]  cell_attr;
    logic [ATTR_W-1:0]  next_cell_attr;
    logic               row_start;
    logic [FADDR_W-1:0] font_addr;
    logic [FDATA_W-1:0] font_data;

    // handshake and stage control
    logic advance;
    logic accept;
    logic is_font;
    logic s1_valid_reg;
    logic s1_valid_next;
    logic m_tvalid_reg;
    logic m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // front stage
    logic [ATTR_W-1:0]  attr_eff;
    logic [COLOR_W-1:0] fg;
    logic [GLINE_W-1:0] gline;
    logic [4:0]         lpr_less;
    logic [LINE_W-1:0]  line_less;
    logic [FADDR_W-1:0] rd_addr;
    crtcr_item_t        item_next;
    crtcr_item_t        s1_item_reg;
    logic [FDATA_W-1:0] glyph;
    logic [PIX_W-1:0]   pixel_colors;

    // field unpacking
    assign char_code      = s_tdata[6:0];
    assign line_index     = s_tdata[10:7];
    assign blank_line     = s_tdata[11];
    assign underline      = s_tdata[12];
    assign cell_attr      = s_tdata[16:13];
    assign next_cell_attr = s_tdata[20:17];
    assign row_start      = s_tdata[21];
    assign font_addr      = s_tdata[32:22];
    assign font_data      = s_tdata[40:33];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg    <= RST_COLOR_MODE;
            font_set_reg      <= 1'b0;
            lines_per_row_reg <= RST_LINES_PER_ROW;
            offset_line_reg   <= 1'b0;
            dashed_ul_reg     <= 1'b0;
            use_reverse_reg   <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_COLOR_MODE:    color_mode_reg    <= cfg_wdata[1:0];
                CFG_FONT_SET:      font_set_reg      <= cfg_wdata[0];
                CFG_LINES_PER_ROW: lines_per_row_reg <= cfg_wdata[4:0];
                CFG_OFFSET_LINE:   offset_line_reg   <= cfg_wdata[0];
                CFG_DASHED_UL:     dashed_ul_reg     <= cfg_wdata[0];
                CFG_USE_REVERSE:   use_reverse_reg   <= cfg_wdata[0];
                default:           ;
            endcase
        end
    end

    // the whole pipe moves when the output register can take a beat
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;
    assign is_font  = (s_tuser == CMD_FONT_WR);

    // attributes and foreground color
    always_comb
    begin
        attr_eff = cell_attr;
        if (color_mode_reg == COLOR_MONO && !s_tlast)
        begin
            attr_eff = next_cell_attr;
        end
        if (color_mode_reg == COLOR_MONO)
        begin
            fg = attr_eff[ATTR_HGLT] ? FG_MONO_HI : FG_MONO_LO;
        end
        else
        begin
            fg = {~attr_eff[ATTR_GPA0], ~attr_eff[ATTR_GPA1], ~attr_eff[ATTR_HGLT]};
        end
    end

    // glyph line and font address
    assign lpr_less  = lines_per_row_reg - 5'd1;
    assign line_less = line_index - LINE_W'(1);

    always_comb
    begin
        if (!offset_line_reg)
        begin
            gline = line_index[GLINE_W-1:0];
        end
        else if (line_index != '0)
        begin
            gline = line_less[GLINE_W-1:0];
        end
        else
        begin
            gline = lpr_less[GLINE_W-1:0];
        end
        rd_addr = {font_set_reg, char_code, gline};
    end

    always_comb
    begin
        item_next.fg         = fg;
        item_next.invert     = attr_eff[ATTR_REV] && use_reverse_reg;
        item_next.underline  = underline;
        item_next.blank      = blank_line;
        item_next.line_index = line_index;
        item_next.row_start  = row_start;
    end

    crtcr_font_ram u_font_ram (
        .clk     (clk),
        .wr_en   (accept && is_font),
        .wr_addr (font_addr),
        .wr_data (font_data),
        .rd_en   (accept && !is_font),
        .rd_addr (rd_addr),
        .rd_data (glyph)
    );

    // stage and output valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance)
        begin
            s1_valid_next = accept && !is_font;
            m_tvalid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_item_reg <= item_next;
        end
    end

    crtcr_render #(
        .CHAR_WIDTH (CHAR_WIDTH),
        .MAX_LINES  (MAX_LINES)
    ) u_render (
        .clk              (clk),
        .rst_n            (rst_n),
        .update           (s1_valid_reg && advance),
        .dashed_underline (dashed_ul_reg),
        .item             (s1_item_reg),
        .glyph            (glyph),
        .pixel_colors     (pixel_colors)
    );

    // output register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            m_tdata_reg <= {{(M_TDATA_W-PIX_W){1'b0}}, pixel_colors};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a font write beat never puts a render beat in flight
    a_font_no_render: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s1_valid_reg)
        else $error("font write produced a render beat");

    // a render beat reaches the pixel stage in the next cycle
    a_render_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> s1_valid_reg)
        else $error("render beat lost before pixel stage");

    // a stalled pixel stage keeps its beat
    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_item_reg)))
        else $error("pixel stage changed while stalled");

    // a moving pixel stage fills the output register
    a_stage_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance) |=> m_tvalid)
        else $error("pixel stage beat dropped");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for crt_char_cell_line_renderer: loads the font store, streams cell
// scan lines under many display settings and checks each pixel beat in order against a predictor.
// Depends on rtl/crtcr_pkg.sv and rtl/crt_char_cell_line_renderer.sv.

module tb;
    import crtcr_pkg::*;

    localparam int         IDLE_PCT       = 34;
    localparam int         DRAIN_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         LOADED_CODES   = 32;
    localparam logic [1:0] COLOR_RESERVED = 2'd3;

    // one input beat, unpacked into its fields
    typedef struct {
        logic               cmd;
        logic [CODE_W-1:0]  char_code;
        logic [LINE_W-1:0]  line_index;
        logic               blank_line;
        logic               underline;
        logic [ATTR_W-1:0]  cell_attr;
        logic [ATTR_W-1:0]  next_cell_attr;
        logic               last_in_row;
        logic               row_start;
        logic [FADDR_W-1:0] font_addr;
        logic [FDATA_W-1:0] font_data;
    } cell_beat_t;

    // full set of display registers
    typedef struct {
        logic [1:0] color_mode;
        logic       font_set;
        logic [4:0] lines_per_row;
        logic       offset_line;
        logic       dashed_ul;
        logic       use_reverse;
    } disp_setting_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // predictor state
    logic [FDATA_W-1:0] glyph_rom [FONT_DEPTH];
    logic               dash_flags [LINE_SPAN];
    disp_setting_t      cur_set;
    logic [PIX_W-1:0]   expected_pixels [$];
    logic [PIX_W-1:0]   exp_pix;

    bit calm = 1'b0;
    int err_count;
    int renders_sent;
    int font_writes_sent;
    int beats_checked;
    int settings_applied;

    crt_char_cell_line_renderer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #(5_000_000);
        $display("Test completed with failures");
        $finish;
    end

    // codes whose glyphs the font load fills: the lowest and the highest sixteen
    function automatic logic [CODE_W-1:0] loaded_code(input logic [CODE_W-1:0] raw);
        return {{3{raw[4]}}, raw[3:0]};
    endfunction

    // expected pixels of one render beat; updates the dashed underline flags
    function automatic logic [PIX_W-1:0] render_cell(input cell_beat_t b);
        logic [ATTR_W-1:0]  attr;
        logic [COLOR_W-1:0] fg;
        logic [4:0]         gline;
        logic [FDATA_W-1:0] glyph;
        logic               cur;
        logic               lit;
        logic [PIX_W-1:0]   pix;
        if (b.row_start)
            foreach (dash_flags[i]) dash_flags[i] = 1'b0;

        // mono takes attributes from the next cell unless this one ends the row
        attr = (cur_set.color_mode == COLOR_MONO && !b.last_in_row) ? b.next_cell_attr
                                                                    : b.cell_attr;
        if (cur_set.color_mode == COLOR_MONO)
            fg = attr[ATTR_HGLT] ? FG_MONO_HI : FG_MONO_LO;
        else
            fg = {~attr[ATTR_GPA0], ~attr[ATTR_GPA1], ~attr[ATTR_HGLT]};

        // glyph line, one earlier in offset mode with wrap to the row's last line
        if (!cur_set.offset_line)
            gline = {1'b0, b.line_index};
        else if (b.line_index != '0)
            gline = {1'b0, b.line_index - LINE_W'(1)};
        else
            gline = cur_set.lines_per_row - 5'd1;
        glyph = glyph_rom[{cur_set.font_set, b.char_code, gline[2:0]}];

        cur = cur_set.dashed_ul ? (b.underline && !dash_flags[b.line_index]) : b.underline;

        // glyph bit set means dark pixel
        pix = '0;
        for (int pt = 0; pt < PIX_COUNT; pt++)
        begin
            lit = cur || !(b.blank_line || glyph[PIX_COUNT-1-pt]);
            if (attr[ATTR_REV] && cur_set.use_reverse)
                lit = !lit;
            if (lit)
                pix[PIX_W-1-COLOR_W*pt -: COLOR_W] = fg;
        end

        if (cur_set.dashed_ul && (cur || !(b.blank_line || glyph[UL_KEEP_BIT])))
            cur = 1'b1;
        dash_flags[b.line_index] = cur;
        return pix;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_beat(input cell_beat_t b);
        return S_TDATA_W'({b.font_data, b.font_addr, b.row_start, b.next_cell_attr,
                           b.cell_attr, b.underline, b.blank_line, b.line_index,
                           b.char_code});
    endfunction

    function automatic cell_beat_t random_beat();
        cell_beat_t b;
        b.cmd            = 1'($urandom_range(1));
        b.char_code      = loaded_code(CODE_W'($urandom));
        b.line_index     = LINE_W'($urandom);
        b.blank_line     = 1'($urandom_range(1));
        b.underline      = 1'($urandom_range(1));
        b.cell_attr      = ATTR_W'($urandom);
        b.next_cell_attr = ATTR_W'($urandom);
        b.last_in_row    = 1'($urandom_range(1));
        b.row_start      = 1'($urandom_range(1));
        b.font_addr      = FADDR_W'($urandom);
        b.font_data      = FDATA_W'($urandom);
        return b;
    endfunction

    function automatic cell_beat_t make_cell(input logic [CODE_W-1:0] code,
                                             input logic [LINE_W-1:0] line,
                                             input logic blank, input logic ul,
                                             input logic [ATTR_W-1:0] attr,
                                             input logic [ATTR_W-1:0] nattr,
                                             input logic last, input logic rstart);
        cell_beat_t b;
        b                = random_beat();
        b.cmd            = CMD_RENDER;
        b.char_code      = code;
        b.line_index     = line;
        b.blank_line     = blank;
        b.underline      = ul;
        b.cell_attr      = attr;
        b.next_cell_attr = nattr;
        b.last_in_row    = last;
        b.row_start      = rstart;
        return b;
    endfunction

    function automatic cell_beat_t make_font_write(input logic [FADDR_W-1:0] addr,
                                                   input logic [FDATA_W-1:0] data);
        cell_beat_t b;
        b           = random_beat();
        b.cmd       = CMD_FONT_WR;
        b.font_addr = addr;
        b.font_data = data;
        return b;
    endfunction

    // drive one beat, wait for the handshake, then update the predictor
    task automatic send_beat(input cell_beat_t b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_beat(b);
        s_tlast  <= b.last_in_row;
        s_tuser  <= b.cmd;
        do @(posedge clk); while (!s_tready);
        if (b.cmd == CMD_FONT_WR)
        begin
            glyph_rom[b.font_addr] = b.font_data;
            font_writes_sent++;
        end
        else
        begin
            expected_pixels.push_back(render_cell(b));
            renders_sent++;
        end
    endtask

    // stop sending and let every expected beat come out
    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_pixels.size() != 0)
        begin
            $error("%0d pixel beats never arrived", expected_pixels.size());
            err_count++;
            expected_pixels.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all registers while idle; junk sets unused high bits of the write data
    task automatic apply_setting(input disp_setting_t c, input bit junk);
        logic [CFG_DATA_W-1:0] v;
        logic [CFG_DATA_W-1:0] fill;
        crtcr_cfg_idx_t        idx;
        wait_idle();
        for (int i = CFG_COLOR_MODE; i <= CFG_USE_REVERSE; i++)
        begin
            idx  = crtcr_cfg_idx_t'(i);
            fill = junk ? CFG_DATA_W'($urandom) : '0;
            case (idx)
                CFG_COLOR_MODE:    v = {fill[4:2], c.color_mode};
                CFG_FONT_SET:      v = {fill[4:1], c.font_set};
                CFG_LINES_PER_ROW: v = c.lines_per_row;
                CFG_OFFSET_LINE:   v = {fill[4:1], c.offset_line};
                CFG_DASHED_UL:     v = {fill[4:1], c.dashed_ul};
                default:           v = {fill[4:1], c.use_reverse};
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= v;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cur_set = c;
        settings_applied++;
    endtask

    // text rows: every scan line of the row over the same cells, row_start on the first beat
    task automatic run_rows(input int n_cells, input int noise_pct, input int wr_pct);
        cell_beat_t        b;
        logic [ATTR_W-1:0] row_attr [11];
        logic [CODE_W-1:0] row_code [10];
        logic              line_blank;
        int                nlines;
        int                ncells;
        int                done;
        done = 0;
        while (done < n_cells)
        begin
            nlines = (cur_set.lines_per_row == 0 || cur_set.lines_per_row > LINE_SPAN)
                     ? LINE_SPAN : int'(cur_set.lines_per_row);
            ncells = $urandom_range(1, 10);
            foreach (row_attr[i]) row_attr[i] = ATTR_W'($urandom);
            foreach (row_code[i]) row_code[i] = loaded_code(CODE_W'($urandom));
            for (int ln = 0; ln < nlines && done < n_cells; ln++)
            begin
                line_blank = ($urandom_range(99) < 15);
                for (int c = 0; c < ncells; c++)
                begin
                    if ($urandom_range(99) < wr_pct)
                        send_beat(make_font_write(FADDR_W'($urandom), FDATA_W'($urandom)));
                    if ($urandom_range(99) < noise_pct)
                    begin
                        b     = random_beat();
                        b.cmd = CMD_RENDER;
                    end
                    else
                        b = make_cell(row_code[c], LINE_W'(ln), line_blank,
                                      $urandom_range(99) < 60,
                                      row_attr[c], row_attr[c+1], c == ncells - 1,
                                      ln == 0 && c == 0);
                    send_beat(b);
                    done++;
                end
            end
        end
    endtask

    // glyphs of the used codes in both font halves, blank and solid at the code extremes
    task automatic test_font_load();
        logic [FDATA_W-1:0] data;
        logic [CODE_W-1:0]  code;
        for (int s = 0; s < 2; s++)
        begin
            for (int k = 0; k < LOADED_CODES; k++)
            begin
                code = loaded_code(CODE_W'(k));
                for (int ln = 0; ln < FONT_LINES; ln++)
                begin
                    if (code == '0)
                        data = '0;
                    else if (code == '1)
                        data = '1;
                    else
                        data = FDATA_W'($urandom);
                    send_beat(make_font_write({s[0], code, ln[2:0]}, data));
                end
            end
        end
        wait_idle();
    endtask

    // field extremes, attributes, blanking, underline and write-then-read of a glyph
    task automatic test_directed_cells();
        send_beat(make_cell(0, 0, 0, 0, 4'h0, 4'h0, 1, 1));
        send_beat(make_cell(127, 15, 0, 0, 4'hF, 4'hF, 1, 0));
        send_beat(make_cell(127, 7, 1, 0, 4'h0, 4'h0, 0, 0));
        send_beat(make_cell(0, 3, 1, 1, 4'h0, 4'hF, 0, 0));
        send_beat(make_cell(127, 3, 0, 1, 4'h1, 4'h0, 0, 0));
        send_beat(make_cell(112, 8, 0, 0, 4'hE, 4'h1, 0, 0));
        send_beat(make_cell(3, 9, 0, 0, 4'h6, 4'h9, 1, 0));
        send_beat(make_font_write({1'b0, 7'd9, 3'd2}, 8'h2A));
        send_beat(make_cell(9, 2, 0, 0, 4'h0, 4'h0, 0, 0));
        send_beat(make_font_write({1'b0, 7'd9, 3'd2}, 8'h15));
        send_beat(make_cell(9, 10, 0, 0, 4'h8, 4'h0, 0, 0));
        send_beat(make_cell(9, 2, 0, 1, 4'h1, 4'h0, 1, 0));
        send_beat(make_font_write({1'b1, 7'd127, 3'd7}, 8'hA5));
        send_beat(make_cell(127, 15, 0, 0, 4'h2, 4'h4, 0, 1));
    endtask

    // fixed settings through the register extremes and special modes
    task automatic test_setting_sweep();
        disp_setting_t sweep [6];
        sweep[0] = '{COLOR_MONO,     1'b0, 5'd10, 1'b0, 1'b0, 1'b1};
        sweep[1] = '{COLOR_GRAY,     1'b1, 5'd1,  1'b1, 1'b0, 1'b1};
        sweep[2] = '{COLOR_RESERVED, 1'b0, 5'd16, 1'b1, 1'b1, 1'b0};
        sweep[3] = '{COLOR_MONO,     1'b1, 5'd0,  1'b1, 1'b1, 1'b1};
        sweep[4] = '{COLOR_COLOR,    1'b1, 5'd31, 1'b1, 1'b0, 1'b0};
        sweep[5] = '{COLOR_MONO,     1'b0, 5'd5,  1'b0, 1'b1, 1'b1};
        foreach (sweep[i])
        begin
            apply_setting(sweep[i], 1'b0);
            run_rows(100, 10, 5);
        end
    endtask

    // both sides always ready, dashed underline on
    task automatic test_back_to_back();
        apply_setting('{COLOR_COLOR, 1'b0, 5'd12, 1'b0, 1'b1, 1'b1}, 1'b0);
        calm = 1'b1;
        run_rows(250, 10, 5);
        wait_idle();
        calm = 1'b0;
    endtask

    // random settings with junk in the unused write bits
    task automatic test_random_settings();
        disp_setting_t s;
        for (int p = 0; p < 10; p++)
        begin
            s.color_mode    = 2'($urandom_range(3));
            s.font_set      = 1'($urandom_range(1));
            s.lines_per_row = 5'($urandom_range(31));
            s.offset_line   = 1'($urandom_range(1));
            s.dashed_ul     = 1'($urandom_range(1));
            s.use_reverse   = 1'($urandom_range(1));
            apply_setting(s, 1'b1);
            run_rows(55, 15, 5);
        end
    endtask

    // output side stalls
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected beat: pixel_colors expected none got %h",
                       m_tdata[PIX_W-1:0]);
                err_count++;
            end
            else
            begin
                exp_pix = expected_pixels.pop_front();
                beats_checked++;
                if (m_tdata[PIX_W-1:0] !== exp_pix)
                begin
                    $error("pixel_colors mismatch: expected %h got %h",
                           exp_pix, m_tdata[PIX_W-1:0]);
                    err_count++;
                end
                if (m_tdata[M_TDATA_W-1:PIX_W] !== '0)
                begin
                    $error("zero fill mismatch: expected 0 got %h", m_tdata[M_TDATA_W-1:PIX_W]);
                    err_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        cur_set = '{RST_COLOR_MODE, 1'b0, RST_LINES_PER_ROW, 1'b0, 1'b0, 1'b1};
        foreach (dash_flags[i]) dash_flags[i] = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_font_load();
        test_directed_cells();
        test_setting_sweep();
        test_back_to_back();
        test_random_settings();
        wait_idle();

        $display("Rendered %0d cell lines and wrote %0d font bytes over %0d register settings.",
                 renders_sent, font_writes_sent, settings_applied);
        $display("Checked %0d pixel beats in mono, color, gray, reserved and dashed modes.",
                 beats_checked);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
